FILE: rtl/core/sofl_pkg.sv
package sofl_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 1024;
   localparam int unsigned DATA_W          = 64;
   localparam int unsigned STATUS_W        = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPENDED       = 3'd0,
      ST_NOT_INCREASING = 3'd1,
      ST_FULL           = 3'd2,
      ST_HIT            = 3'd3,
      ST_MISS           = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RSP_APPEND = 2'd0,
      RSP_HIT    = 2'd1,
      RSP_MISS   = 2'd2
   } rsp_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        probe;
      logic        fetch;
      logic        step;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_open;
      logic lo_zero;
      logic out_free;
   } dp_sts_type;

endpackage

FILE: rtl/core/sofl_ctrl.sv
module sofl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   output sofl_pkg::dp_cmd_type cmd,
   input  sofl_pkg::dp_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND,
      S_SEARCH,
      S_CMP,
      S_HIT,
      S_MISS
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = req_action ? S_SEARCH : S_APPEND;
            end
         end
         S_APPEND: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = sofl_pkg::RSP_APPEND;
               state_in     = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (sts.search_open) begin
               cmd.probe = 1'b1;
               state_in  = S_CMP;
            end else if (sts.lo_zero) begin
               state_in = S_MISS;
            end else begin
               // The floor entry sits just below the first key above the query.
               cmd.fetch = 1'b1;
               state_in  = S_HIT;
            end
         end
         S_CMP: begin
            cmd.step = 1'b1;
            state_in = S_SEARCH;
         end
         S_HIT: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = sofl_pkg::RSP_HIT;
               state_in     = S_IDLE;
            end
         end
         S_MISS: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = sofl_pkg::RSP_MISS;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/sofl_dpath.sv
module sofl_dpath #(
   parameter int unsigned TABLE_DEPTH = sofl_pkg::TABLE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [sofl_pkg::DATA_W-1:0]      req_key_offset,
   input  logic [sofl_pkg::DATA_W-1:0]      req_segment_base,
   input  logic [sofl_pkg::DATA_W-1:0]      req_byte_pos,
   input  sofl_pkg::dp_cmd_type             cmd,
   output sofl_pkg::dp_sts_type             sts,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sofl_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sofl_pkg::DATA_W-1:0]      rsp_found_key,
   output logic [sofl_pkg::DATA_W-1:0]      rsp_found_segment_base,
   output logic [sofl_pkg::DATA_W-1:0]      rsp_found_byte_pos
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned DW = sofl_pkg::DATA_W;

   logic [DW-1:0] key_mem [TABLE_DEPTH];
   logic [DW-1:0] seg_mem [TABLE_DEPTH];
   logic [DW-1:0] pos_mem [TABLE_DEPTH];

   logic [CW-1:0] count_ff;
   logic [CW-1:0] lo_ff;
   logic [CW-1:0] hi_ff;
   logic [CW-1:0] mid_ff;
   logic [DW-1:0] key_ff;
   logic [DW-1:0] seg_ff;
   logic [DW-1:0] pos_ff;
   logic [DW-1:0] last_key_ff;
   logic [DW-1:0] rd_key_ff;
   logic [DW-1:0] rd_seg_ff;
   logic [DW-1:0] rd_pos_ff;

   logic                      rsp_valid_ff;
   logic [sofl_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DW-1:0]             rsp_key_ff;
   logic [DW-1:0]             rsp_seg_ff;
   logic [DW-1:0]             rsp_pos_ff;

   logic [CW-1:0]             mid_in;
   logic [CW-1:0]             lo_m1;
   logic [AW-1:0]             rd_addr;
   logic                      rd_en;
   logic                      not_incr;
   logic                      table_full;
   logic                      wr_en;
   sofl_pkg::status_type      app_status;
   logic                      out_free;

   assign mid_in  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_m1   = lo_ff - CW'(1);
   assign rd_en   = cmd.probe | cmd.fetch;
   assign rd_addr = cmd.fetch ? lo_m1[AW-1:0] : mid_in[AW-1:0];

   // The key check takes precedence over the full check.
   assign not_incr   = (count_ff != '0) && (last_key_ff >= key_ff);
   assign table_full = (count_ff == CW'(TABLE_DEPTH));

   always_comb begin
      if (not_incr) begin
         app_status = sofl_pkg::ST_NOT_INCREASING;
      end else if (table_full) begin
         app_status = sofl_pkg::ST_FULL;
      end else begin
         app_status = sofl_pkg::ST_APPENDED;
      end
   end

   assign wr_en = cmd.rsp_load && (cmd.rsp_sel == sofl_pkg::RSP_APPEND) &&
                  !not_incr && !table_full;

   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign sts.search_open = (lo_ff < hi_ff);
   assign sts.lo_zero     = (lo_ff == '0);
   assign sts.out_free    = out_free;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[count_ff[AW-1:0]] <= key_ff;
         seg_mem[count_ff[AW-1:0]] <= seg_ff;
         pos_mem[count_ff[AW-1:0]] <= pos_ff;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_seg_ff <= seg_mem[rd_addr];
         rd_pos_ff <= pos_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= req_key_offset;
         seg_ff <= req_segment_base;
         pos_ff <= req_byte_pos;
      end
      if (cmd.probe) begin
         mid_ff <= mid_in;
      end
      if (wr_en) begin
         last_key_ff <= key_ff;
      end
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_sel)
            sofl_pkg::RSP_APPEND: begin
               rsp_status_ff <= app_status;
               rsp_key_ff    <= '0;
               rsp_seg_ff    <= '0;
               rsp_pos_ff    <= '0;
            end
            sofl_pkg::RSP_HIT: begin
               rsp_status_ff <= sofl_pkg::ST_HIT;
               rsp_key_ff    <= rd_key_ff;
               rsp_seg_ff    <= rd_seg_ff;
               rsp_pos_ff    <= rd_pos_ff;
            end
            default: begin
               rsp_status_ff <= sofl_pkg::ST_MISS;
               rsp_key_ff    <= '0;
               rsp_seg_ff    <= '0;
               rsp_pos_ff    <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.capture) begin
            lo_ff <= '0;
            hi_ff <= count_ff;
         end else if (cmd.step) begin
            // Narrow towards the first entry whose key lies above the query.
            if (key_ff < rd_key_ff) begin
               hi_ff <= mid_ff;
            end else begin
               lo_ff <= mid_ff + CW'(1);
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_found_key          = rsp_key_ff;
   assign rsp_found_segment_base = rsp_seg_ff;
   assign rsp_found_byte_pos     = rsp_pos_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count exceeds the table depth");

   a_interval : assert property (@(posedge clock) disable iff (reset)
      (lo_ff <= hi_ff) && (hi_ff <= count_ff))
      else $error("search interval lies outside the written entries");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> out_free)
      else $error("result loaded over a beat not yet taken");

   a_append_count : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append did not advance the entry count");

endmodule

FILE: rtl/core/sorted_offset_index_floor_lookup.sv
// Sorted floor-lookup index.
// Request channel (req_): one beat per item. req_action 0 appends the entry
// {req_key_offset, req_segment_base, req_byte_pos} if its key is above the last
// stored key and the table is not full; req_action 1 looks up the entry with
// the greatest key not above req_key_offset. Response channel (rsp_): one beat
// per request, carrying a status code and, on a lookup hit, the stored entry
// (zero fields otherwise). Items are handled one at a time. A lookup runs a
// binary search on a single registered read port of the entry memories, with
// at most P = ceil(log2(entries + 1)) probes; the read of the floor entry
// overlaps the final interval check. req_ready returns when the result is
// loaded, even if the receiver has not taken the previous beat; an item that
// finishes while the register is still occupied waits until it is free.
// Reset empties the table and drops any pending response; memory contents are
// not cleared, as only written entries are ever read.
module sorted_offset_index_floor_lookup #(
   parameter int unsigned TABLE_DEPTH = sofl_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [sofl_pkg::DATA_W-1:0]    req_key_offset,
   input  logic [sofl_pkg::DATA_W-1:0]    req_segment_base,
   input  logic [sofl_pkg::DATA_W-1:0]    req_byte_pos,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sofl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sofl_pkg::DATA_W-1:0]    rsp_found_key,
   output logic [sofl_pkg::DATA_W-1:0]    rsp_found_segment_base,
   output logic [sofl_pkg::DATA_W-1:0]    rsp_found_byte_pos
);

   sofl_pkg::dp_cmd_type cmd;
   sofl_pkg::dp_sts_type sts;

   sofl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   sofl_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .req_key_offset         (req_key_offset),
      .req_segment_base       (req_segment_base),
      .req_byte_pos           (req_byte_pos),
      .cmd                    (cmd),
      .sts                    (sts),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_found_key          (rsp_found_key),
      .rsp_found_segment_base (rsp_found_segment_base),
      .rsp_found_byte_pos     (rsp_found_byte_pos)
   );

endmodule

FILE: tb/sv/sorted_offset_index_floor_lookup_test.sv
module sorted_offset_index_floor_lookup_test;

   localparam int unsigned DEPTH        = sofl_pkg::TABLE_DEPTH_DEF;
   localparam logic        ACT_APPEND   = 1'b0;
   localparam logic        ACT_LOOKUP   = 1'b1;
   localparam logic [63:0] KEY_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FIRST_KEY    = 64'h0000_0001_0000_0000;
   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned RANDOM_ITEMS = 1750;
   localparam int unsigned PHASES       = 4;

   typedef struct packed {
      sofl_pkg::status_type status;
      logic [63:0]          key;
      logic [63:0]          seg;
      logic [63:0]          pos;
   } index_result_type;

   typedef struct packed {
      logic             action;
      logic [63:0]      key;
      logic [63:0]      seg;
      logic [63:0]      pos;
      logic             typed;
      index_result_type want;
   } stim_row_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_action       = 1'b0;
   logic [63:0] req_key_offset   = '0;
   logic [63:0] req_segment_base = '0;
   logic [63:0] req_byte_pos     = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_found_key;
   logic [63:0] rsp_found_segment_base;
   logic [63:0] rsp_found_byte_pos;

   // Side information travelling with the request beat.
   logic             rq_typed = 1'b0;
   index_result_type rq_want  = '0;

   int unsigned tx_idle_pct  = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned failures     = 0;
   int unsigned quiet_cycles = 0;

   // Predictor copy of the table.
   logic [63:0] pred_keys [DEPTH];
   logic [63:0] pred_segs [DEPTH];
   logic [63:0] pred_poss [DEPTH];
   int unsigned pred_count = 0;

   index_result_type pending_results [$];
   stim_row_type     directed_rows [$];
   logic [63:0]      stim_keys [$];

   sorted_offset_index_floor_lookup #(
      .TABLE_DEPTH(DEPTH)
   ) u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_action             (req_action),
      .req_key_offset         (req_key_offset),
      .req_segment_base       (req_segment_base),
      .req_byte_pos           (req_byte_pos),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_found_key          (rsp_found_key),
      .rsp_found_segment_base (rsp_found_segment_base),
      .rsp_found_byte_pos     (rsp_found_byte_pos)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_field();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return KEY_MAX;
      return rand64();
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      failures++;
      if (failures <= 100) $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   task automatic predict_floor(input logic action, input logic [63:0] key,
                                input logic [63:0] seg, input logic [63:0] pos,
                                output index_result_type res);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      res = '0;
      if (action == ACT_APPEND) begin
         if (pred_count > 0 && pred_keys[pred_count-1] >= key) begin
            res.status = sofl_pkg::ST_NOT_INCREASING;
         end else if (pred_count >= DEPTH) begin
            res.status = sofl_pkg::ST_FULL;
         end else begin
            pred_keys[pred_count] = key;
            pred_segs[pred_count] = seg;
            pred_poss[pred_count] = pos;
            pred_count++;
            res.status = sofl_pkg::ST_APPENDED;
         end
      end else begin
         // Find the first entry whose key is above the query.
         lo = 0;
         hi = pred_count;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key < pred_keys[mid]) hi = mid;
            else lo = mid + 1;
         end
         if (lo == 0) begin
            res.status = sofl_pkg::ST_MISS;
         end else begin
            res.status = sofl_pkg::ST_HIT;
            res.key    = pred_keys[lo-1];
            res.seg    = pred_segs[lo-1];
            res.pos    = pred_poss[lo-1];
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
   end

   // Checks response beats against the oldest expectation and records one per request beat.
   always @(posedge clock) begin : monitor
      index_result_type want;
      index_result_type pred;
      logic             moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected beat, status", {61'b0, rsp_status}, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", {61'b0, rsp_status}, {61'b0, want.status});
               if (rsp_found_key !== want.key)
                  report_mismatch("found_key", rsp_found_key, want.key);
               if (rsp_found_segment_base !== want.seg)
                  report_mismatch("found_segment_base", rsp_found_segment_base, want.seg);
               if (rsp_found_byte_pos !== want.pos)
                  report_mismatch("found_byte_pos", rsp_found_byte_pos, want.pos);
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            predict_floor(req_action, req_key_offset, req_segment_base, req_byte_pos, pred);
            pending_results = {pending_results, (rq_typed ? rq_want : pred)};
         end
         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("Some tests failed");
               $finish;
            end
         end
      end
   end

   task automatic add_row(input logic action, input logic [63:0] key, input logic [63:0] seg,
                          input logic [63:0] pos, input logic typed,
                          input sofl_pkg::status_type st,
                          input logic [63:0] fk, input logic [63:0] fs, input logic [63:0] fp);
      stim_row_type row;
      row.action      = action;
      row.key         = key;
      row.seg         = seg;
      row.pos         = pos;
      row.typed       = typed;
      row.want.status = st;
      row.want.key    = fk;
      row.want.seg    = fs;
      row.want.pos    = fp;
      directed_rows   = {directed_rows, row};
   endtask

   task automatic send_item(input logic action, input logic [63:0] key, input logic [63:0] seg,
                            input logic [63:0] pos, input logic typed,
                            input index_result_type want);
      int unsigned n;
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_key_offset   <= key;
      req_segment_base <= seg;
      req_byte_pos     <= pos;
      rq_typed         <= typed;
      rq_want          <= want;
      // Keep the stimulus side's view of the stored keys for choosing later items.
      n = stim_keys.size();
      if (action == ACT_APPEND && n < DEPTH && (n == 0 || key > stim_keys[n-1]))
         stim_keys = {stim_keys, key};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic make_random_item(output logic action, output logic [63:0] key,
                                   output logic [63:0] seg, output logic [63:0] pos);
      int unsigned n;
      int unsigned r;
      int unsigned grow_pct;
      int unsigned drop_pct;
      logic [63:0] last;
      logic [63:0] remaining;
      logic [63:0] span;
      logic [63:0] pick;
      logic [64:0] gap;
      n        = stim_keys.size();
      last     = (n != 0) ? stim_keys[n-1] : '0;
      seg      = rand_field();
      pos      = rand_field();
      action   = ACT_LOOKUP;
      key      = rand64();
      r        = $urandom_range(99);
      grow_pct = (n < DEPTH) ? 74 : 15;
      drop_pct = (n < DEPTH) ? 82 : 35;
      if (r < grow_pct && last != KEY_MAX) begin
         action    = ACT_APPEND;
         remaining = KEY_MAX - last;
         if ($urandom_range(9) < 3) begin
            gap = 65'd1;
         end else begin
            // Spread the gaps so that the keys climb through the whole range as the table fills.
            span = remaining / ((n < DEPTH) ? (DEPTH - n) : 1);
            gap  = 65'd1 + ({1'b0, rand64()} % ({1'b0, span} * 65'd2 + 65'd1));
            if (gap > {1'b0, remaining}) gap = {1'b0, remaining};
         end
         key = last + gap[63:0];
      end else if (n >= DEPTH && r < 25) begin
         action = ACT_APPEND;
         key    = KEY_MAX;
      end else if (r < drop_pct && n != 0) begin
         action = ACT_APPEND;
         case ($urandom_range(2))
            0: begin
               key = last;
            end
            1: begin
               key = stim_keys[$urandom_range(n-1)];
            end
            default: begin
               gap = {1'b0, rand64()} % ({1'b0, last} + 65'd1);
               key = gap[63:0];
            end
         endcase
      end else begin
         case ($urandom_range(5))
            0, 1: begin
               if (n != 0) key = stim_keys[$urandom_range(n-1)];
            end
            2: begin
               if (n != 0) begin
                  pick = stim_keys[$urandom_range(n-1)];
                  if ($urandom_range(1) == 0) key = (pick == KEY_MAX) ? pick : pick + 64'd1;
                  else key = (pick == 0) ? pick : pick - 64'd1;
               end
            end
            3: begin
               key = rand64();
            end
            4: begin
               key = ($urandom_range(1) == 0) ? '0 : KEY_MAX;
            end
            default: begin
               if (n != 0 && stim_keys[0] != 0) key = rand64() % stim_keys[0];
            end
         endcase
      end
   endtask

   initial begin : stimulus
      logic        action;
      logic [63:0] key;
      logic [63:0] seg;
      logic [63:0] pos;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_row(ACT_LOOKUP, '0, '0, '0, 1'b1, sofl_pkg::ST_MISS, '0, '0, '0);
      add_row(ACT_LOOKUP, KEY_MAX, KEY_MAX, KEY_MAX, 1'b1, sofl_pkg::ST_MISS, '0, '0, '0);
      add_row(ACT_APPEND, FIRST_KEY, '0, '0, 1'b1, sofl_pkg::ST_APPENDED, '0, '0, '0);
      add_row(ACT_APPEND, FIRST_KEY, KEY_MAX, KEY_MAX, 1'b1, sofl_pkg::ST_NOT_INCREASING,
              '0, '0, '0);
      add_row(ACT_APPEND, '0, KEY_MAX, KEY_MAX, 1'b1, sofl_pkg::ST_NOT_INCREASING,
              '0, '0, '0);
      add_row(ACT_LOOKUP, FIRST_KEY - 64'd1, '0, '0, 1'b1, sofl_pkg::ST_MISS, '0, '0, '0);
      add_row(ACT_LOOKUP, FIRST_KEY, '0, '0, 1'b1, sofl_pkg::ST_HIT, FIRST_KEY, '0, '0);
      add_row(ACT_LOOKUP, KEY_MAX, '0, '0, 1'b1, sofl_pkg::ST_HIT, FIRST_KEY, '0, '0);
      add_row(ACT_APPEND, FIRST_KEY + 64'd1, KEY_MAX, KEY_MAX, 1'b1, sofl_pkg::ST_APPENDED,
              '0, '0, '0);
      add_row(ACT_LOOKUP, FIRST_KEY + 64'd1, '0, '0, 1'b1, sofl_pkg::ST_HIT,
              FIRST_KEY + 64'd1, KEY_MAX, KEY_MAX);
      add_row(ACT_APPEND, FIRST_KEY + 64'd2, 64'h5555_5555_5555_5555,
              64'hAAAA_AAAA_AAAA_AAAA, 1'b1, sofl_pkg::ST_APPENDED, '0, '0, '0);
      add_row(ACT_LOOKUP, FIRST_KEY + 64'd1, '0, '0, 1'b0, sofl_pkg::ST_APPENDED,
              '0, '0, '0);
      add_row(ACT_LOOKUP, KEY_MAX, '0, '0, 1'b0, sofl_pkg::ST_APPENDED, '0, '0, '0);
      add_row(ACT_LOOKUP, FIRST_KEY, '0, '0, 1'b0, sofl_pkg::ST_APPENDED, '0, '0, '0);
      add_row(ACT_APPEND, FIRST_KEY + 64'd2, '0, '0, 1'b1, sofl_pkg::ST_NOT_INCREASING,
              '0, '0, '0);
      add_row(ACT_APPEND, FIRST_KEY + 64'h10, 64'h0123_4567_89AB_CDEF,
              64'hFEDC_BA98_7654_3210, 1'b0, sofl_pkg::ST_APPENDED, '0, '0, '0);
      add_row(ACT_LOOKUP, FIRST_KEY + 64'hF, '0, '0, 1'b0, sofl_pkg::ST_APPENDED,
              '0, '0, '0);
      add_row(ACT_LOOKUP, 64'h8000_0000_0000_0000, '0, '0, 1'b0, sofl_pkg::ST_APPENDED,
              '0, '0, '0);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].action, directed_rows[i].key, directed_rows[i].seg,
                   directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct  = 56;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 56;
            end
            default: begin
               tx_idle_pct  = 20;
               rx_stall_pct = 20;
            end
         endcase
         repeat (RANDOM_ITEMS / PHASES) begin
            make_random_item(action, key, seg, pos);
            send_item(action, key, seg, pos, 1'b0, '0);
         end
      end

      req_valid    <= 1'b0;
      rx_stall_pct  = 0;
      while (pending_results.size() != 0) @(posedge clock);
      // Let any stray beat show up before the verdict.
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
